// ===== hw/rtl/int_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_macros.svh
// Assertion macros shared by the integer-to-ASCII block.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define I2DA_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define I2DA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer-to-decimal-ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Magnitude fits 10 decimal digits (2^31 < 10^10)
   localparam int MAX_DIGITS = 10;
   localparam int DIG_IDX_W  = $clog2(MAX_DIGITS + 1);

   // floor(n / 10) == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
   localparam logic [63:0] RECIP_TEN = 64'h0000_0000_CCCC_CCCD;
   localparam int          QUOT_LSB  = 35;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture input value
      logic div_step;    // peel one digit off the magnitude
      logic emit_sign;   // drive '-' beat
      logic emit_digit;  // drive next digit beat, most significant first
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;    // quotient of this step is zero
      logic negative;    // captured value was negative
      logic last_digit;  // one digit left to emit
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2da_ctrl
// Sequencer: accept, divide loop, optional sign beat, digit beats.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire i2da_pkg::status_type sts,
   output      logic                 busy,
   output      i2da_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = sts.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.emit_digit = 1'b1;
            if (sts.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2da_dp.sv =====
// ----------------------------------------------------------------------------
// i2da_dp
// Datapath: magnitude register, divide-by-ten step, digit store, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic signed [31:0]   req_value,
   input  wire i2da_pkg::cmd_type    cmd,
   output      i2da_pkg::status_type sts,
   output      logic                 rsp_valid,
   output      logic [7:0]           rsp_char_code,
   output      logic                 rsp_is_last
);

   localparam int IdxW = i2da_pkg::DIG_IDX_W;

   logic [31:0]     mag_ff;
   logic [31:0]     mag_in;
   logic            neg_ff;
   logic            neg_in;
   logic [IdxW-1:0] ndig_ff;
   logic [IdxW-1:0] ndig_in;
   logic [3:0]      digit_ff [i2da_pkg::MAX_DIGITS];
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_last_ff;
   logic            rsp_last_in;
   logic [7:0]      rsp_char_ff;
   logic [7:0]      rsp_char_in;

   logic [31:0]     raw;
   logic [31:0]     mag_load;
   logic [63:0]     prod;
   logic [31:0]     quot;
   logic [3:0]      q10_lo;
   logic [3:0]      rem;
   logic [IdxW-1:0] rd_idx;

   // Two's complement magnitude; 0x80000000 stays as 2^31
   assign raw      = req_value;
   assign mag_load = raw[31] ? (~raw + 32'd1) : raw;

   // Divide by ten through the reciprocal; remainder needs only four bits
   assign prod   = {32'd0, mag_ff} * i2da_pkg::RECIP_TEN;
   assign quot   = 32'(prod >> i2da_pkg::QUOT_LSB);
   assign q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign rem    = mag_ff[3:0] - q10_lo;

   assign rd_idx = ndig_ff - IdxW'(1);

   // Status back to the controller
   assign sts.div_done   = (quot == 32'd0);
   assign sts.negative   = neg_ff;
   assign sts.last_digit = (ndig_ff == IdxW'(1));

   // Next-state logic for magnitude, count and result beat
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_char_in  = rsp_char_ff;
      if (cmd.load) begin
         mag_in  = mag_load;
         neg_in  = raw[31];
         ndig_in = '0;
      end
      if (cmd.div_step) begin
         mag_in  = quot;
         ndig_in = ndig_ff + IdxW'(1);
      end
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = i2da_pkg::CHAR_MINUS;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (ndig_ff == IdxW'(1));
         rsp_char_in  = i2da_pkg::CHAR_ZERO + {4'b0000, digit_ff[rd_idx]};
         ndig_in      = rd_idx;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      ndig_ff     <= ndig_in;
      rsp_char_ff <= rsp_char_in;
   end

   // Digit store, least significant digit at index zero
   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         digit_ff[ndig_ff] <= rem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// One divide-by-ten step per cycle fills the digit store, then one beat per character.
// Busy covers the divide loop, the sign state and the digit states; the next item
// can be accepted in the cycle that shows the last character.
// Results cannot be stalled. Synchronous active-high reset returns to idle, no beat.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII characters, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic signed [31:0] req_value,
   output      logic               rsp_valid,
   output      logic [7:0]         rsp_char_code,
   output      logic               rsp_is_last
);

   i2da_pkg::cmd_type    cmd;
   i2da_pkg::status_type sts;

   i2da_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   i2da_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   // Checks
   `I2DA_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one command active")
   `I2DA_ASSERT_SAME(a_last_idle, clock, reset, rsp_valid && rsp_is_last, !busy, "busy at last")
   `I2DA_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, busy && !rsp_valid, "early beat")
   `I2DA_ASSERT_SAME(a_last_valid, clock, reset, rsp_is_last, rsp_valid, "last flag without beat")

endmodule

`default_nettype wire

// ===== dv/int_to_decimal_ascii_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_checker
// Watches the request and character channels of the converter. Every accepted
// request is spelled out into its expected character beats. Each rsp_valid
// beat is then compared with the oldest expected beat.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [31:0] req_value,
   input  wire logic               rsp_valid,
   input  wire logic [7:0]         rsp_char_code,
   input  wire logic               rsp_is_last,
   output      int                 mismatches,
   output      int                 chars_outstanding
);

   localparam int unsigned RADIX = 10;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } ascii_beat_type;

   ascii_beat_type pending_chars[$];
   int             error_count = 0;
   int             queued = 0;

   assign mismatches        = error_count;
   assign chars_outstanding = queued;

   // Expected text of one value: optional sign, then digits most significant first
   function automatic void spell_decimal(input logic [31:0] value);
      bit [32:0]      magnitude;
      bit [3:0]       digit_lsf[10];
      int             ndigits;
      int             k;
      ascii_beat_type beat;
      ndigits = 0;
      // 33 bits so the most negative value does not wrap
      magnitude = value[31] ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
      do begin
         digit_lsf[ndigits] = 4'(magnitude % RADIX);
         magnitude          = magnitude / RADIX;
         ndigits++;
      end while (magnitude != 0);
      if (value[31]) begin
         beat.char_code = i2da_pkg::CHAR_MINUS;
         beat.is_last   = 1'b0;
         pending_chars.push_back(beat);
      end
      for (k = ndigits - 1; k >= 0; k--) begin
         beat.char_code = i2da_pkg::CHAR_ZERO + 8'(digit_lsf[k]);
         beat.is_last   = (k == 0);
         pending_chars.push_back(beat);
      end
   endfunction

   // Compare the character beat first, then queue up a newly accepted request
   always @(posedge clock) begin : watch
      ascii_beat_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected character beat: char_code %h is_last %b",
                      rsp_char_code, rsp_is_last);
               error_count++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code mismatch: expected %h actual %h",
                         want.char_code, rsp_char_code);
                  error_count++;
               end
               if (rsp_is_last !== want.is_last) begin
                  $error("is_last mismatch: expected %b actual %b",
                         want.is_last, rsp_is_last);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            spell_decimal(req_value);
         queued = pending_chars.size();
      end
   end

endmodule

// ===== dv/int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_tb
// Drives signed integers into the converter. A directed set covers zero, the
// extremes, powers of ten and alternating bit patterns. Random values follow,
// spread over every digit count and both signs, under three sender idle
// rates. The checker beside the block predicts and compares the characters.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_tb;

   localparam int NUM_DIRECTED = 25;
   localparam int NUM_RANDOM   = 155;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [31:0] req_value = '0;
   logic               busy;
   logic               rsp_valid;
   logic [7:0]         rsp_char_code;
   logic               rsp_is_last;
   int                 mismatches;
   int                 chars_outstanding;
   int                 cycle_count = 0;
   int                 idle_pct = 0;

   always #5 clock = ~clock;

   int_to_decimal_ascii DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   int_to_decimal_ascii_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_char_code     (rsp_char_code),
      .rsp_is_last       (rsp_is_last),
      .mismatches        (mismatches),
      .chars_outstanding (chars_outstanding)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("int_to_decimal_ascii_tb NOT OK");
         $finish;
      end
   end

   // Directed values: zero, single digits, digit-count boundaries, extremes
   function automatic logic [31:0] directed_value(input int idx);
      case (idx)
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return -32'sd1;
         3:       return 32'd9;
         4:       return -32'sd9;
         5:       return 32'd10;
         6:       return -32'sd10;
         7:       return 32'd99;
         8:       return 32'd100;
         9:       return -32'sd100;
         10:      return 32'd12345;
         11:      return -32'sd67890;
         12:      return 32'd999999999;
         13:      return 32'd1000000000;
         14:      return -32'sd999999999;
         15:      return -32'sd1000000000;
         16:      return 32'd1999999999;
         17:      return 32'h7FFF_FFFF;
         18:      return 32'h8000_0001;
         19:      return 32'h8000_0000;
         20:      return 32'h5555_5555;
         21:      return 32'hAAAA_AAAA;
         22:      return 32'h0F0F_0F0F;
         23:      return 32'hF0F0_F0F0;
         default: return 32'd7;
      endcase
   endfunction

   // Random value: full-range bits, a chosen digit count, small, or near an edge
   function automatic logic [31:0] random_value();
      longint lo;
      longint hi;
      longint mag;
      longint pow;
      int     ndigits;
      int     k;
      logic   neg;
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6, 7: begin
            ndigits = $urandom_range(1, 10);
            lo = 1;
            for (k = 1; k < ndigits; k++)
               lo = lo * 10;
            hi = lo * 10 - 1;
            if (ndigits == 1)
               lo = 0;
            if (hi > 64'sd2147483648)
               hi = 64'sd2147483648;
            mag = lo + (longint'($urandom()) % (hi - lo + 1));
            if (!neg && mag > 64'sd2147483647)
               mag = 64'sd2147483647;
            return neg ? 32'(-mag) : 32'(mag);
         end
         8: return 32'($urandom_range(0, 40)) - 32'd20;
         default: begin
            pow = 1;
            for (k = $urandom_range(1, 9); k > 0; k--)
               pow = pow * 10;
            case ($urandom_range(0, 5))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               3:       return neg ? 32'(-pow) : 32'(pow);
               4:       return neg ? 32'(1 - pow) : 32'(pow - 1);
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   // Sender idles at random before offering the next beat
   task automatic idle_gap();
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Offer one request beat and hold it until accepted
   task automatic send_value(input logic [31:0] value);
      idle_gap();
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      do
         @(posedge clock);
      while (busy);
   endtask

   initial begin : stimulus
      int i;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      for (i = 0; i < NUM_DIRECTED; i++)
         send_value(directed_value(i));

      // Three idle regimes: light, heavy, none
      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i < NUM_RANDOM / 3)
            idle_pct = 14;
         else if (i < 2 * NUM_RANDOM / 3)
            idle_pct = 87;
         else
            idle_pct = 0;
         send_value(random_value());
      end

      @(negedge clock);
      start <= 1'b0;

      while (chars_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("int_to_decimal_ascii_tb OK");
      else
         $display("int_to_decimal_ascii_tb NOT OK");
      $finish;
   end

endmodule
